// ===== rtl/core/lokf_pkg.sv =====
// Package for the longest-ones-window block.
// Holds the result beat type and the fixed field widths; no dependencies.
package lokf_pkg;

  localparam int unsigned BestWidth   = 16;
  localparam int unsigned BudgetWidth = 4;

  // One result beat as it leaves the window unit.
  typedef struct packed {
    logic                 last_result;
    logic                 too_long;
    logic [BestWidth-1:0] best_length;
  } lokf_result_t;

endpackage

// ===== rtl/core/longest_ones_window_with_k_flips.sv =====
// Longest run of ones with at most max_flips zeros flipped, one bit per beat.
// Each result beat is registered in the output buffer before it is offered on the m_axis side.
// Throughput: one bit per cycle while s_axis_tready is high; the window start comes straight from the zero ring.
// A two-entry output buffer keeps accepting while one result waits downstream.
// Reset (rst_ni low, asynchronous) clears the window state and max_flips to zero.
// Depends on lokf_pkg, lokf_window and lokf_skid.
module longest_ones_window_with_k_flips
  import lokf_pkg::*;
#(
  parameter int unsigned FLIP_LIMIT    = 15,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_wr_en_i,
  input  logic [BudgetWidth-1:0] cfg_wr_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,  // [0] bit_value, rest zero
  input  logic                   s_axis_tlast,  // last_item
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [23:0]            m_axis_tdata,  // [15:0] best_length, [16] too_long
  output logic                   m_axis_tlast   // last_result
);

  logic [BudgetWidth-1:0] max_flips_q;
  logic                   accept;
  lokf_result_t           result;
  lokf_result_t           out_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_flips_q <= '0;
    end else if (cfg_wr_en_i) begin
      max_flips_q <= cfg_wr_data_i;
    end
  end

  assign accept = s_axis_tvalid & s_axis_tready;

  lokf_window #(
    .FLIP_LIMIT   (FLIP_LIMIT),
    .POSITION_BITS(POSITION_BITS)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .bit_value_i(s_axis_tdata[0]),
    .last_item_i(s_axis_tlast),
    .max_flips_i(max_flips_q),
    .result_o   (result)
  );

  lokf_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (result),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (out_data)
  );

  assign m_axis_tdata = {7'b0, out_data.too_long, out_data.best_length};
  assign m_axis_tlast = out_data.last_result;

endmodule

// ===== rtl/core/lokf_window.sv =====
// Sliding-window state and zero-position ring for the longest-ones-window block.
// Computes one result per accepted bit. Depends on lokf_pkg.
module lokf_window
  import lokf_pkg::*;
#(
  parameter int unsigned FLIP_LIMIT    = 15,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic                   bit_value_i,
  input  logic                   last_item_i,
  input  logic [BudgetWidth-1:0] max_flips_i,
  output lokf_result_t           result_o
);

  localparam int unsigned Depth = FLIP_LIMIT + 1;
  localparam int unsigned CW    = $clog2(FLIP_LIMIT + 2);
  localparam int unsigned RW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned SW    = RW + 1;
  localparam int unsigned PB    = POSITION_BITS;

  logic [PB-1:0] position_q, position_d;
  logic [PB-1:0] start_q, start_d;
  logic [CW-1:0] zeros_q, zeros_d;
  logic [RW-1:0] head_q, head_d;
  logic [RW-1:0] tail_q, tail_d;
  logic [PB-1:0] best_q, best_d;
  logic          ovf_q, ovf_d;

  logic [PB-1:0] ring_q [Depth];

  logic          full;
  logic          is_zero;
  logic [CW-1:0] budget;
  logic [CW-1:0] count_inc;
  logic [CW-1:0] drop;
  logic [SW-1:0] idx_sum, head_sum;
  logic [RW-1:0] idx;
  logic [PB-1:0] rd_pos;
  logic [PB-1:0] pos_next;
  logic [PB-1:0] len;
  logic          ring_we;

  // The budget register is clamped to what the ring can hold.
  always_comb begin
    if (32'(max_flips_i) > FLIP_LIMIT) begin
      budget = CW'(FLIP_LIMIT);
    end else begin
      budget = CW'(max_flips_i);
    end
  end

  assign full      = (position_q == {PB{1'b1}});
  assign is_zero   = ~bit_value_i;
  assign count_inc = zeros_q + CW'(is_zero);
  assign drop      = count_inc - budget;
  assign ring_we   = accept_i & ~full & is_zero;

  // Slot of the last zero that leaves the window, and the new ring head.
  always_comb begin
    idx_sum  = {1'b0, head_q} + SW'(drop) - SW'(1);
    head_sum = {1'b0, head_q} + SW'(drop);
    if (idx_sum >= SW'(Depth)) begin
      idx_sum = idx_sum - SW'(Depth);
    end
    if (head_sum >= SW'(Depth)) begin
      head_sum = head_sum - SW'(Depth);
    end
  end

  assign idx = idx_sum[RW-1:0];

  // The slot being written this beat is read back through a bypass.
  assign rd_pos   = (is_zero && (idx == tail_q)) ? position_q : ring_q[idx];
  assign pos_next = position_q + PB'(1);

  always_comb begin
    position_d = position_q;
    start_d    = start_q;
    zeros_d    = zeros_q;
    head_d     = head_q;
    tail_d     = tail_q;
    best_d     = best_q;
    ovf_d      = ovf_q;
    len        = '0;
    if (accept_i) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        if (is_zero) begin
          if (32'(tail_q) == Depth - 1) begin
            tail_d = '0;
          end else begin
            tail_d = tail_q + RW'(1);
          end
        end
        zeros_d = count_inc;
        if (count_inc > budget) begin
          start_d = rd_pos + PB'(1);
          head_d  = head_sum[RW-1:0];
          zeros_d = budget;
        end
        position_d = pos_next;
        len        = pos_next - start_d;
        if (len > best_q) begin
          best_d = len;
        end
      end
    end
  end

  generate
    if (PB > BestWidth) begin : g_sat
      assign result_o.best_length = (|best_d[PB-1:BestWidth]) ? {BestWidth{1'b1}}
                                                               : best_d[BestWidth-1:0];
    end else begin : g_ext
      assign result_o.best_length = BestWidth'(best_d);
    end
  endgenerate

  assign result_o.too_long    = ovf_d;
  assign result_o.last_result = last_item_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q <= '0;
      start_q    <= '0;
      zeros_q    <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      best_q     <= '0;
      ovf_q      <= 1'b0;
    end else if (accept_i && last_item_i) begin
      position_q <= '0;
      start_q    <= '0;
      zeros_q    <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      best_q     <= '0;
      ovf_q      <= 1'b0;
    end else begin
      position_q <= position_d;
      start_q    <= start_d;
      zeros_q    <= zeros_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      best_q     <= best_d;
      ovf_q      <= ovf_d;
    end
  end

  // Ring entries are only read after being written in the same sequence.
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_q[tail_q] <= position_q;
    end
  end

endmodule

// ===== rtl/core/lokf_skid.sv =====
// Two-entry output buffer for result beats.
// Keeps the input side open while a finished beat waits downstream. Depends on lokf_pkg.
module lokf_skid
  import lokf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  lokf_result_t in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output lokf_result_t out_data_o
);

  logic         out_valid_q;
  logic         skid_valid_q;
  lokf_result_t out_q;
  lokf_result_t skid_q;
  logic         push;
  logic         pop;

  assign in_ready_o  = ~skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign push        = in_valid_i & ~skid_valid_q;
  assign pop         = out_valid_q & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      if (!out_valid_q || pop) begin
        out_q <= in_data_i;
      end else begin
        skid_q <= in_data_i;
      end
    end else if (pop && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

endmodule

// ===== tb/longest_ones_window_with_k_flips_tb.sv =====
// Testbench for longest_ones_window_with_k_flips: random streams of bits against an
// in-bench window predictor, with random source gaps and sink stalls.
// Depends on lokf_pkg and the block's RTL.
`timescale 1ns / 100ps

module longest_ones_window_with_k_flips_tb;
  import lokf_pkg::*;

  localparam int unsigned RingDepth = 16;
  localparam logic [15:0] PosMax    = 16'hFFFF;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_wr_en_i = 1'b0;
  logic [BudgetWidth-1:0] cfg_wr_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata = '0;  // [0] bit_value, rest zero
  logic                   s_axis_tlast = 1'b0;  // last_item
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [23:0]            m_axis_tdata;  // [15:0] best_length, [16] too_long
  logic                   m_axis_tlast;  // last_result

  // Predictor state for the current sequence.
  logic [15:0]            seq_pos;
  logic [15:0]            win_start;
  logic [4:0]             zero_count;
  logic [15:0]            zero_ring [RingDepth];
  logic [3:0]             ring_rd;
  logic [3:0]             ring_wr;
  logic [15:0]            best_len;
  logic                   overflow_seen;
  logic [BudgetWidth-1:0] flip_budget;

  lokf_result_t           pending_results [$];
  int unsigned            mismatch_count = 0;
  int unsigned            src_idle_pct = 0;
  int unsigned            sink_idle_pct = 0;
  int unsigned            stall_left = 0;

  longest_ones_window_with_k_flips dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void clear_window_state();
    seq_pos       = '0;
    win_start     = '0;
    zero_count    = '0;
    ring_rd       = '0;
    ring_wr       = '0;
    best_len      = '0;
    overflow_seen = 1'b0;
  endfunction

  // Advances the window by one bit and returns the result beat it should produce.
  function automatic lokf_result_t predict_best_window(logic bit_in, logic last_in);
    lokf_result_t res;
    logic [4:0]   zcount;
    logic [4:0]   drop;
    logic [3:0]   slot;
    logic [15:0]  span;
    if (seq_pos == PosMax) begin
      overflow_seen = 1'b1;
    end else begin
      zcount = zero_count;
      if (!bit_in) begin
        zero_ring[ring_wr] = seq_pos;
        ring_wr = ring_wr + 4'd1;
        zcount = zcount + 5'd1;
      end
      // All zeros beyond the budget leave at once; the start jumps past the last one.
      if (zcount > {1'b0, flip_budget}) begin
        drop = zcount - {1'b0, flip_budget};
        slot = ring_rd + 4'(drop - 5'd1);
        win_start = zero_ring[slot] + 16'd1;
        ring_rd = ring_rd + drop[3:0];
        zcount = {1'b0, flip_budget};
      end
      zero_count = zcount;
      seq_pos = seq_pos + 16'd1;
      span = seq_pos - win_start;
      if (span > best_len) best_len = span;
    end
    res.best_length = best_len;
    res.too_long    = overflow_seen;
    res.last_result = last_in;
    if (last_in) clear_window_state();
    return res;
  endfunction

  function automatic int unsigned pick_gap(int unsigned idle_pct);
    if ($urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(24, 8);
    return $urandom_range(3, 1);
  endfunction

  // Result checker: every accepted result beat is matched against the oldest prediction.
  always @(posedge clk_i) begin
    lokf_result_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: best_length %0d", m_axis_tdata[15:0]);
        mismatch_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (m_axis_tdata[15:0] !== exp_res.best_length) begin
          $error("best_length: expected %0d, got %0d", exp_res.best_length,
                 m_axis_tdata[15:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[16] !== exp_res.too_long) begin
          $error("too_long: expected %0b, got %0b", exp_res.too_long, m_axis_tdata[16]);
          mismatch_count++;
        end
        if (m_axis_tlast !== exp_res.last_result) begin
          $error("last_result: expected %0b, got %0b", exp_res.last_result, m_axis_tlast);
          mismatch_count++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left = pick_gap(sink_idle_pct);
    end
  end

  task automatic send_bit(logic bit_in, logic last_in);
    int unsigned gap;
    gap = pick_gap(src_idle_pct);
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, bit_in};
    s_axis_tlast  <= last_in;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results = {pending_results, predict_best_window(bit_in, last_in)};
  endtask

  // Sends bits from the LSB up; the final one is flagged last when end_seq is set.
  task automatic send_bits(logic [31:0] bits, int unsigned count, logic end_seq);
    for (int unsigned i = 0; i < count; i++) begin
      send_bit(bits[i], end_seq && (i == count - 1));
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_budget(logic [BudgetWidth-1:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    flip_budget = value;
  endtask

  // Budget zero straight out of reset: each zero pushes the start just past itself.
  task automatic test_budget_zero();
    src_idle_pct  = 30;
    sink_idle_pct = 30;
    send_bits(32'b1001101, 7, 1'b1);
    send_bits(32'b0, 1, 1'b1);
    send_bits(32'b1, 1, 1'b1);
  endtask

  task automatic test_budget_one();
    set_budget(4'd1);
    send_bits(32'b011010, 6, 1'b1);
  endtask

  // Lowering the budget mid-sequence drops every surplus zero on the next beat.
  task automatic test_budget_lowered();
    set_budget(4'd3);
    send_bits(32'b0100, 4, 1'b0);
    set_budget(4'd0);
    send_bits(32'b11, 2, 1'b1);
  endtask

  task automatic test_random_sequences();
    int unsigned sent;
    int unsigned len;
    int unsigned ones_pct;
    int unsigned group;
    logic [BudgetWidth-1:0] budget;
    sent  = 0;
    group = 0;
    while (sent < 420) begin
      if (group == 0) begin
        set_budget(4'd15);
      end else if (group == 1) begin
        set_budget(4'd0);
      end else if ($urandom_range(2) == 0) begin
        case ($urandom_range(3))
          0:       budget = 4'd0;
          1:       budget = 4'd15;
          default: budget = 4'($urandom_range(15));
        endcase
        set_budget(budget);
      end
      case ($urandom_range(19))
        0:       len = $urandom_range(200, 100);
        1, 2, 3: len = $urandom_range(80, 31);
        default: len = $urandom_range(30, 1);
      endcase
      ones_pct = ($urandom_range(1) == 0) ? $urandom_range(100) : $urandom_range(95, 50);
      case ($urandom_range(2))
        0:       src_idle_pct = 0;
        1:       src_idle_pct = 15;
        default: src_idle_pct = 40;
      endcase
      case ($urandom_range(2))
        0:       sink_idle_pct = 0;
        1:       sink_idle_pct = 15;
        default: sink_idle_pct = 40;
      endcase
      for (int unsigned i = 0; i < len; i++) begin
        if (len > 4 && i == len / 2 && $urandom_range(5) == 0) begin
          set_budget(4'($urandom_range(15)));
        end
        send_bit($urandom_range(99) < ones_pct, i == len - 1);
      end
      sent += len;
      group++;
    end
  endtask

  initial begin
    clear_window_state();
    flip_budget = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_budget_zero();
    test_budget_one();
    test_budget_lowered();
    test_random_sequences();

    drain_results();
    repeat (5) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/lokf_pkg.sv
rtl/core/lokf_window.sv
rtl/core/lokf_skid.sv
rtl/core/longest_ones_window_with_k_flips.sv
tb/longest_ones_window_with_k_flips_tb.sv
